>>> hdl/dtse_pkg.sv
// Shared types and constants for the date-time string to epoch converter.
package dtse_pkg;

	localparam int CHAR_W     = 21;
	localparam int VAL_W      = 12;
	localparam int LEN_W      = 6;
	localparam int NFIELDS    = 6;
	localparam int FC_W       = 3;
	localparam int SECS_W     = 32;
	localparam int MAX_DIGITS = 32;

	// field slots in arrival order
	localparam int F_YEAR   = 0;
	localparam int F_MONTH  = 1;
	localparam int F_DAY    = 2;
	localparam int F_HOUR   = 3;
	localparam int F_MINUTE = 4;
	localparam int F_SECOND = 5;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} req_t;

	typedef struct packed {
		logic              valid_res;
		logic [SECS_W-1:0] seconds;
	} rsp_t;

	typedef logic [NFIELDS-1:0][VAL_W-1:0] fvals_t;

	// completed string: parsed fields plus the long-run flag
	typedef struct packed {
		logic   ovf;
		fvals_t vals;
	} fields_t;

endpackage

>>> hdl/datetime_string_to_epoch.sv
// Top level of the date-time string to Unix seconds converter.
// A date-time string comes in one character per request, with last set on the final
// character. Runs of ASCII digits are fields (year, month, day, hour, minute, second);
// any other code separates them, runs past the sixth are ignored and a missing field is 0.
// A run longer than MAX_DIGITS digits (32 by default), or a field out of range (year
// 1970..2038, month <= 13, day <= 32, hour <= 24, minute and second <= 60), gives a
// response with valid_res low and seconds 0. Only the final character produces a
// response; the parser then clears for the next string. One character is taken every
// cycle, including the cycle after a final character, except while a final character
// waits for a free field register. A response passes from its final character through
// the input register, field register, day/second split register and result register.
// The result register decouples the two sides, so requests keep flowing while a
// response waits; the output stalls the input only once every stage holds a string end.
module datetime_string_to_epoch #(
	parameter int MAX_DIGITS = dtse_pkg::MAX_DIGITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  dtse_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dtse_pkg::rsp_t rsp
);
	import dtse_pkg::*;

	// parsed fields of a finished string, parser -> converter
	logic    fld_valid;
	logic    fld_ready;
	fields_t fld;

	dtse_parse #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.fld_valid (fld_valid),
		.fld_ready (fld_ready),
		.fld       (fld)
	);

	dtse_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.fld_valid (fld_valid),
		.fld_ready (fld_ready),
		.fld       (fld),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

>>> hdl/dtse_parse.sv
// Character input register and digit-run parser that collects the six date-time fields.
module dtse_parse #(
	parameter int MAX_DIGITS = dtse_pkg::MAX_DIGITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  dtse_pkg::req_t   req,
	output logic             fld_valid,
	input  logic             fld_ready,
	output dtse_pkg::fields_t fld
);
	import dtse_pkg::*;

	localparam int                PROD_W    = VAL_W + 4;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_NINE = CHAR_W'(57);
	localparam logic [VAL_W-1:0]  VALUE_MAX = '1;
	localparam logic [LEN_W-1:0]  LEN_MAX   = '1;

	logic              s1_valid_q;
	req_t              req_s1;
	logic [VAL_W-1:0]  run_val_q;
	logic [LEN_W-1:0]  run_len_q;
	logic [FC_W-1:0]   fc_q;
	fvals_t            vals_q;
	logic              ovf_q;
	logic              fld_valid_q;
	fields_t           fld_s2;

	logic              s2_free;
	logic              consume;
	logic              active;
	logic              is_dig;
	logic              close_run;
	logic              store;
	logic [PROD_W-1:0] prod;
	logic [VAL_W-1:0]  acc_val;
	logic [LEN_W-1:0]  acc_len;
	logic              ovf_nxt;
	fvals_t            vals_nxt;
	logic [FC_W-1:0]   fc_nxt;

	assign s2_free   = !fld_valid_q || fld_ready;
	// a final character needs a free slot downstream; others never stall
	assign consume   = s1_valid_q && (!req_s1.last || s2_free);
	assign req_ready = !s1_valid_q || consume;

	always_comb begin
		active = fc_q < FC_W'(NFIELDS);
		is_dig = (req_s1.char_code >= CHAR_ZERO) && (req_s1.char_code <= CHAR_NINE);
		// x*10 as shift-add, then the digit (low nibble of the code)
		prod = {1'b0, run_val_q, 3'b000} + {3'b000, run_val_q, 1'b0}
			+ PROD_W'(req_s1.char_code[3:0]);

		acc_val = run_val_q;
		acc_len = run_len_q;
		ovf_nxt = ovf_q;
		if (active && is_dig) begin
			acc_val = (prod > PROD_W'(VALUE_MAX)) ? VALUE_MAX : prod[VAL_W-1:0];
			if (run_len_q != LEN_MAX) begin
				acc_len = run_len_q + LEN_W'(1);
			end
			if (run_len_q >= LEN_W'(MAX_DIGITS)) begin
				ovf_nxt = 1'b1;
			end
		end

		close_run = (active && !is_dig) || req_s1.last;
		store     = close_run && active && (acc_len != '0);
		vals_nxt  = vals_q;
		if (store) begin
			vals_nxt[fc_q] = acc_val;
		end
		fc_nxt = fc_q + FC_W'(store);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			fld_valid_q <= 1'b0;
			run_val_q   <= '0;
			run_len_q   <= '0;
			fc_q        <= '0;
			vals_q      <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (req_ready) begin
				s1_valid_q <= req_valid;
			end
			if (consume && req_s1.last) begin
				fld_valid_q <= 1'b1;
			end else if (fld_ready) begin
				fld_valid_q <= 1'b0;
			end
			if (consume) begin
				if (req_s1.last) begin
					run_val_q <= '0;
					run_len_q <= '0;
					fc_q      <= '0;
					vals_q    <= '0;
					ovf_q     <= 1'b0;
				end else begin
					run_val_q <= close_run ? '0 : acc_val;
					run_len_q <= close_run ? '0 : acc_len;
					fc_q      <= fc_nxt;
					vals_q    <= vals_nxt;
					ovf_q     <= ovf_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (consume && req_s1.last) begin
			fld_s2.ovf  <= ovf_nxt;
			fld_s2.vals <= vals_nxt;
		end
	end

	assign fld_valid = fld_valid_q;
	assign fld       = fld_s2;

endmodule

>>> hdl/dtse_conv.sv
// Range check and table conversion of the parsed fields into Unix seconds, with result register.
module dtse_conv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fld_valid,
	output logic              fld_ready,
	input  dtse_pkg::fields_t fld,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output dtse_pkg::rsp_t    rsp
);
	import dtse_pkg::*;

	localparam int DAYS_W  = 15;
	localparam int HMS_W   = 17;
	localparam int YIDX_W  = 7;
	localparam int MDAYS_W = 9;

	localparam logic [VAL_W-1:0]  YEAR_MIN    = VAL_W'(1970);
	localparam logic [VAL_W-1:0]  YEAR_MAX    = VAL_W'(2038);
	localparam logic [VAL_W-1:0]  MONTH_MAX   = VAL_W'(13);
	localparam logic [VAL_W-1:0]  DAY_MAX     = VAL_W'(32);
	localparam logic [VAL_W-1:0]  HOUR_MAX    = VAL_W'(24);
	localparam logic [VAL_W-1:0]  MINSEC_MAX  = VAL_W'(60);
	localparam logic [SECS_W-1:0] SEC_PER_DAY = SECS_W'(86400);

	// days before the first of month m; months 0 and 1 give none, 13 gives a full year
	function automatic logic [MDAYS_W-1:0] month_days(input logic [3:0] m);
		logic [MDAYS_W-1:0] d;
		unique case (m)
			4'd2:    d = MDAYS_W'(31);
			4'd3:    d = MDAYS_W'(59);
			4'd4:    d = MDAYS_W'(90);
			4'd5:    d = MDAYS_W'(120);
			4'd6:    d = MDAYS_W'(151);
			4'd7:    d = MDAYS_W'(181);
			4'd8:    d = MDAYS_W'(212);
			4'd9:    d = MDAYS_W'(243);
			4'd10:   d = MDAYS_W'(273);
			4'd11:   d = MDAYS_W'(304);
			4'd12:   d = MDAYS_W'(334);
			4'd13:   d = MDAYS_W'(365);
			default: d = '0;
		endcase
		return d;
	endfunction

	logic [VAL_W-1:0]  year, month, day, hour, minute, second;
	logic [VAL_W-1:0]  yoff;
	logic [YIDX_W-1:0] idx;
	logic [YIDX_W:0]   idx_p1;
	logic              leap;
	logic              ok;
	logic [DAYS_W-1:0] yr_days, mo_days, day_days, days;
	logic [HMS_W-1:0]  hms;

	logic              s3_valid_q;
	logic              ok_s3;
	logic [DAYS_W-1:0] days_s3;
	logic [HMS_W-1:0]  hms_s3;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              out_free;
	logic              s3_free;
	logic [SECS_W-1:0] secs;

	always_comb begin
		year   = fld.vals[F_YEAR];
		month  = fld.vals[F_MONTH];
		day    = fld.vals[F_DAY];
		hour   = fld.vals[F_HOUR];
		minute = fld.vals[F_MINUTE];
		second = fld.vals[F_SECOND];

		ok = !fld.ovf && (year >= YEAR_MIN) && (year <= YEAR_MAX) && (month <= MONTH_MAX)
			&& (day <= DAY_MAX) && (hour <= HOUR_MAX) && (minute <= MINSEC_MAX)
			&& (second <= MINSEC_MAX);

		// within 1970..2038 every fourth year from 1972 is leap, 2000 included
		yoff   = year - YEAR_MIN;
		idx    = yoff[YIDX_W-1:0];
		idx_p1 = {1'b0, idx} + (YIDX_W+1)'(1);
		leap   = (idx[1:0] == 2'b10);

		yr_days  = DAYS_W'(idx) * DAYS_W'(365) + DAYS_W'(idx_p1[YIDX_W:2]);
		mo_days  = DAYS_W'(month_days(month[3:0]))
			+ DAYS_W'(leap && (month >= VAL_W'(3)));
		day_days = (day > VAL_W'(1)) ? DAYS_W'(day - VAL_W'(1)) : '0;
		days     = yr_days + mo_days + day_days;

		hms = HMS_W'(hour[4:0]) * HMS_W'(3600) + HMS_W'(minute[5:0]) * HMS_W'(60)
			+ HMS_W'(second[5:0]);
	end

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign s3_free   = !s3_valid_q || out_free;
	assign fld_ready = s3_free;

	assign secs = SECS_W'(days_s3) * SEC_PER_DAY + SECS_W'(hms_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s3_free) begin
				s3_valid_q <= fld_valid;
			end
			if (out_free) begin
				rsp_valid_q <= s3_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && fld_valid) begin
			ok_s3   <= ok;
			days_s3 <= days;
			hms_s3  <= hms;
		end
		if (out_free && s3_valid_q) begin
			rsp_q.valid_res <= ok_s3;
			rsp_q.seconds   <= ok_s3 ? secs : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hdl/dtse_checker.sv
// Port-level checks for the date-time converter, bound to its top level.
module dtse_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input dtse_pkg::rsp_t rsp
);
	import dtse_pkg::*;

	// latest instant the range checks allow: 2038, month 13, day 32, 24:60:60
	localparam logic [SECS_W-1:0] SECS_LIMIT = SECS_W'(64'd2180221260);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.valid_res |-> rsp.seconds == '0)
		else $error("failed conversion carries nonzero seconds");

	a_secs_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.valid_res |-> rsp.seconds <= SECS_LIMIT)
		else $error("seconds beyond the accepted date range");

	// with the output draining, an offered request is never stalled
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !rsp_valid && $past(!rsp_valid) && $past(!rsp_valid, 2)
		&& $past(!rsp_valid, 3) |-> req_ready)
		else $error("request stalled while the pipeline is draining");

endmodule

bind datetime_string_to_epoch dtse_checker u_dtse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
